/* sv/earliest_free_worker_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the earliest-free worker scheduler
// Concurrent property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/efws_pkg.sv */
// ----------------------------------------------------------------------------
// efws_pkg
// Shared constants, heap entry type and ordering function for the scheduler.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int MAX_WORKERS = 256;
  localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int CH_W        = IDX_W + 2;
  localparam int TIME_W      = 63;
  localparam int DUR_W       = 32;
  localparam int WID_W       = 8;
  localparam int CFG_W       = 9;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [IDX_W-1:0]  id;
    logic [TIME_W-1:0] tfree;
  } entry_t;

  // True when entry a strictly precedes entry b in (free time, worker) order.
  function automatic logic efws_before(entry_t a, entry_t b);
    logic res;
    if (a.tfree != b.tfree) begin
      res = (a.tfree < b.tfree);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

  // Low eight bits of a worker number.
  function automatic logic [WID_W-1:0] efws_wid(logic [IDX_W-1:0] id);
    logic [31:0] ext;
    ext = 32'(id);
    return ext[WID_W-1:0];
  endfunction

endpackage

/* sv/earliest_free_worker_scheduler.sv */
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler
// Assigns each job to the worker that frees up first, using a min-heap in RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                         | Word
//  ---------+-----------------------------------+------------------------------
//  input    | start & !busy                     | in_duration
//  result   | out_valid (one cycle, no stall)   | out_worker_id, out_start_time
//  config   | psel & penable & pwrite & pready  | worker_count at byte address 0
//
// After an accept, busy stays high while the entry sinks, and drops once the
// entry settles in a slot with no child in the heap or stops at a slot whose
// children both follow it. Each level costs a read state for both children
// on the two read ports of the heap RAM and a compare state that writes back
// one slot. With 256 workers the worst case sinks eight levels down to the
// last slot. A new job is accepted only once busy has dropped.
// The result word appears in the cycle after the accept and is never held off.
// Reset, and any write of worker_count, reloads the heap at once through one
// valid flop per slot; there is no clearing pass.
//
`include "earliest_free_worker_scheduler_defines.svh"

module earliest_free_worker_scheduler
  import efws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Job input.
  input  logic                start,
  output logic                busy,
  input  logic [DUR_W-1:0]    in_duration,
  // Result output.
  output logic                out_valid,
  output logic [WID_W-1:0]    out_worker_id,
  output logic [TIME_W-1:0]   out_start_time,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

  // Heap slot 0 lives in root_r so that a new job can start without a RAM
  // read. Slots 1 and up live in mem_r; a slot whose valid flop is clear
  // reads as its reset value, worker number equal to slot number, time zero.
  state_t                     state_r;
  logic [CNT_W-1:0]           count_r;
  logic [MAX_WORKERS-1:0]     vld_r;
  entry_t                     root_r;
  entry_t                     cur_r;
  logic [IDX_W-1:0]           pos_r;
  logic                       lin_r;
  logic                       rin_r;
  logic                       out_valid_r;
  logic [WID_W-1:0]           out_wid_r;
  logic [TIME_W-1:0]          out_time_r;

  entry_t                     mem_r [MAX_WORKERS];
  entry_t                     rd_l_q;
  entry_t                     rd_r_q;
  logic                       vl_q;
  logic                       vr_q;
  logic [IDX_W-1:0]           al_q;
  logic [IDX_W-1:0]           ar_q;

  logic                       cfg_wr;
  logic [CFG_W-1:0]           cfg_val;
  logic [CNT_W-1:0]           cfg_count;
  logic [CH_W-1:0]            l_idx;
  logic [CH_W-1:0]            r_idx;
  logic [CH_W-1:0]            n_ext;
  logic                       lin;
  logic                       rin;
  logic [IDX_W-1:0]           ra_l;
  logic [IDX_W-1:0]           ra_r;
  logic [TIME_W:0]            sum;
  logic [TIME_W-1:0]          new_time;
  entry_t                     child_l;
  entry_t                     child_r;
  entry_t                     best;
  logic                       take_l;
  logic                       take_r;
  logic                       move;
  entry_t                     best_child;
  logic [IDX_W-1:0]           best_idx;
  logic                       wr_en;
  entry_t                     wr_data;
  logic                       mem_we;

  // --------------------------------------------------------------------------
  // Configuration decode. Zero counts as one worker and anything above the
  // heap size is clamped to it.
  // --------------------------------------------------------------------------
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign cfg_val = pwdata[CFG_W-1:0];

  always_comb begin
    if (cfg_val == '0) begin
      cfg_count = CNT_W'(1);
    end else if (32'(cfg_val) > MAX_WORKERS) begin
      cfg_count = CNT_W'(MAX_WORKERS);
    end else begin
      cfg_count = CNT_W'(cfg_val);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(count_r) : '0;

  // --------------------------------------------------------------------------
  // Sift-down datapath.
  // --------------------------------------------------------------------------
  // New free time of the root worker, saturating at the largest time value.
  assign sum      = {1'b0, root_r.tfree} + (TIME_W + 1)'(in_duration);
  assign new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  // Children of the current slot and whether they are part of the heap.
  assign l_idx = {1'b0, pos_r, 1'b1};
  assign r_idx = l_idx + CH_W'(1);
  assign n_ext = CH_W'(count_r);
  assign lin   = (l_idx < n_ext);
  assign rin   = (r_idx < n_ext);
  assign ra_l  = l_idx[IDX_W-1:0];
  assign ra_r  = r_idx[IDX_W-1:0];

  always_comb begin
    child_l = vl_q ? rd_l_q : entry_t'{id: al_q, tfree: '0};
    child_r = vr_q ? rd_r_q : entry_t'{id: ar_q, tfree: '0};
    take_l  = lin_r && efws_before(child_l, cur_r);
    best    = take_l ? child_l : cur_r;
    take_r  = rin_r && efws_before(child_r, best);
    move    = take_l || take_r;
    best_child = take_r ? child_r : child_l;
    best_idx   = take_r ? ar_q : al_q;

    // The moving entry settles at the current slot when it has no child left
    // or no child precedes it; otherwise the smaller child moves up.
    wr_en   = 1'b0;
    wr_data = cur_r;
    case (state_r)
      ST_READ: wr_en = !lin;
      ST_CMP: begin
        wr_en   = 1'b1;
        wr_data = move ? best_child : cur_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign mem_we = wr_en && (pos_r != '0);

  // Heap RAM: one write port, two registered read ports. A level writes its
  // current slot while the read ports address that slot's children, so the same
  // entry is never read and written in one cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[pos_r] <= wr_data;
    end
    rd_l_q <= mem_r[ra_l];
    rd_r_q <= mem_r[ra_r];
    vl_q   <= vld_r[ra_l];
    vr_q   <= vld_r[ra_r];
    al_q   <= ra_l;
    ar_q   <= ra_r;
  end

  // --------------------------------------------------------------------------
  // Control: state, worker count, valid flops, root slot and result word.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CNT_W'(1);
      vld_r       <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            out_valid_r <= 1'b1;
            out_wid_r   <= efws_wid(root_r.id);
            out_time_r  <= root_r.tfree;
            cur_r       <= '{id: root_r.id, tfree: new_time};
            pos_r       <= '0;
            state_r     <= ST_READ;
          end
        end
        ST_READ: begin
          lin_r   <= lin;
          rin_r   <= rin;
          state_r <= lin ? ST_CMP : ST_IDLE;
        end
        ST_CMP: begin
          if (move) begin
            pos_r   <= best_idx;
            state_r <= ST_READ;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (wr_en && (pos_r == '0)) begin
        root_r <= wr_data;
      end
      if (mem_we) begin
        vld_r[pos_r] <= 1'b1;
      end

      // A count write reloads the whole heap at once.
      if (cfg_wr) begin
        count_r <= cfg_count;
        vld_r   <= '0;
        root_r  <= '0;
      end
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_worker_id  = out_wid_r;
  assign out_start_time = out_time_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `EFWS_ASSERT_NEXT(a_result_follows_accept, start && !busy, out_valid,
    "accepted job produced no result word in the next cycle")
  `EFWS_ASSERT_SAME(a_result_while_sifting, out_valid, busy,
    "result word issued without a sift-down in progress")
  `EFWS_ASSERT_SAME(a_pos_in_heap, busy, CH_W'(pos_r) < n_ext,
    "sift-down position outside the active heap")
  `EFWS_ASSERT_NEXT(a_cfg_reload, cfg_wr, (root_r == '0) && (vld_r == '0),
    "worker count write did not reload the heap")

endmodule

/* bench/tb_earliest_free_worker_scheduler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the earliest-free worker scheduler
// Drives job words through the start/busy handshake and writes worker_count
// over the APB-style port. A scoreboard keeps its own min-heap of workers,
// predicts the worker and start tick of every accepted job and checks each
// result word against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_earliest_free_worker_scheduler
  import efws_pkg::*;
();

  // Byte addresses on the configuration port. Only worker_count is mapped;
  // the next slot up has no register behind it and must ignore writes.
  localparam logic [2:0] WORKER_COUNT_ADDR = 3'd0;
  localparam logic [2:0] UNMAPPED_ADDR     = 3'd4;
  localparam int         WORKER_COUNT_REG  = 0;

  // The slowest job keeps busy high until its entry has sunk through every level of the heap.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_JOBS    = 135;
  localparam int MAX_GAP       = 20;

  // One predicted result word: who runs the job and when it starts.
  typedef struct {
    logic [WID_W-1:0]  worker;
    logic [TIME_W-1:0] start_tick;
  } assignment_t;

  // Scoreboard: a private copy of the worker heap plus the queue of
  // assignments that the block still owes us.
  class assignment_tracker;
    entry_t          slots[MAX_WORKERS];
    int unsigned     workers;
    assignment_t     pending_assignments[$];
    int unsigned     errors;

    function new();
      errors = 0;
      reload_heap(1);
    endfunction

    function void reload_heap(int unsigned count);
      workers = count;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        slots[i].id    = IDX_W'(i);
        slots[i].tfree = '0;
      end
    endfunction

    function int unsigned pending_count();
      return pending_assignments.size();
    endfunction

    // Register write seen on the port. Zero means one worker, anything over
    // the heap size is clamped, and unmapped addresses change nothing.
    function void write_reg(logic [2:0] addr, logic [31:0] data);
      int unsigned count;
      if ((addr >> 2) != WORKER_COUNT_REG) return;
      count = 32'(data[CFG_W-1:0]);
      if (count == 0) count = 1;
      if (count > MAX_WORKERS) count = MAX_WORKERS;
      reload_heap(count);
    endfunction

    // Strict (free time, worker number) ordering between two heap slots.
    function bit frees_sooner(int a, int b);
      if (slots[a].tfree != slots[b].tfree) return slots[a].tfree < slots[b].tfree;
      return slots[a].id < slots[b].id;
    endfunction

    // The root worker takes the job; its free time moves on by the duration
    // (saturating) and the root then sinks to its place.
    function void note_job(logic [DUR_W-1:0] duration);
      assignment_t     due;
      logic [TIME_W:0] finish;
      entry_t          tmp;
      int              p, l, r, pick;
      due.worker     = WID_W'(slots[0].id);
      due.start_tick = slots[0].tfree;
      pending_assignments.push_back(due);
      finish = {1'b0, slots[0].tfree} + (TIME_W+1)'(duration);
      slots[0].tfree = (finish > {1'b0, TIME_MAX}) ? TIME_MAX : finish[TIME_W-1:0];
      p = 0;
      forever begin
        l    = 2 * p + 1;
        r    = 2 * p + 2;
        pick = p;
        if (l < workers && frees_sooner(l, pick)) pick = l;
        if (r < workers && frees_sooner(r, pick)) pick = r;
        if (pick == p) break;
        tmp         = slots[p];
        slots[p]    = slots[pick];
        slots[pick] = tmp;
        p           = pick;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(logic [WID_W-1:0] worker, logic [TIME_W-1:0] start_tick);
      assignment_t due;
      if (pending_assignments.size() == 0) begin
        report($sformatf("result word (worker %0d, start %0d) with no job waiting",
                         worker, start_tick));
        return;
      end
      due = pending_assignments.pop_front();
      if (worker !== due.worker)
        report($sformatf("worker_id %0d, expected %0d", worker, due.worker));
      if (start_tick !== due.start_tick)
        report($sformatf("start_time %0d, expected %0d", start_tick, due.start_tick));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [DUR_W-1:0]   in_duration;
  logic               out_valid;
  logic [WID_W-1:0]   out_worker_id;
  logic [TIME_W-1:0]  out_start_time;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  assignment_tracker  ledger;
  int unsigned        cycle_count;

  earliest_free_worker_scheduler u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_duration    (in_duration),
    .out_valid      (out_valid),
    .out_worker_id  (out_worker_id),
    .out_start_time (out_start_time),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("earliest_free_worker_scheduler verification failed");
      $finish;
    end
  end

  // Everything the block accepts is observed here, at the rising edge, from
  // values that settled at the previous falling edge. The result word of a
  // job comes only after its accept, so checking before noting keeps the
  // queue in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_result(out_worker_id, out_start_time);
      if (start && !busy) ledger.note_job(in_duration);
      if (psel && penable && pwrite && pready) ledger.write_reg(paddr, pwdata);
    end
  end

  // Job durations: plenty of tiny values so that free times tie and the
  // worker-number tie break is exercised, plus the extremes and full-range
  // random words so that every bit toggles.
  function automatic logic [DUR_W-1:0] random_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DUR_W'($urandom_range(7));
      5:       return DUR_W'($urandom_range(1000));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  // Worker-count write data: the legal extremes, the clamped cases (zero and
  // above the heap size), and random counts. Bits above the register's width
  // are sometimes set; the block must drop them.
  function automatic logic [31:0] random_count_word();
    logic [31:0] word;
    case ($urandom_range(9))
      0:       word = 32'd1;
      1:       word = 32'd256;
      2:       word = 32'd0;
      3:       word = 32'($urandom_range(257, 511));
      4, 5, 6: word = 32'($urandom_range(2, 9));
      default: word = 32'($urandom_range(10, 255));
    endcase
    if ($urandom_range(1)) word[31:CFG_W] = (32-CFG_W)'($urandom);
    return word;
  endfunction

  // Offers one job word. Called at a falling edge and returns at a falling
  // edge, so start stays high when the next job follows at once, and drops
  // only for an idle gap.
  task automatic send_job(logic [DUR_W-1:0] duration, int gap_pct);
    int gap;
    if ($urandom_range(99) < gap_pct) begin
      gap   = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_duration <= duration;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stops offering jobs until every result word has come back and the
  // sift-down of the last job has finished, then idles for the settle period
  // so that a register write never lands on a busy heap.
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (ledger.pending_count() != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then the access cycle; the write happens at the edge where
  // pready is seen high.
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int gap_pct;
    int sent;
    int seg;
    int k;

    ledger      = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_duration = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Out of reset there is a single worker, so start times
    // simply accumulate, including after the largest duration.
    send_job(32'd5, 0);
    send_job(32'd0, 0);
    send_job(32'hFFFF_FFFF, 0);
    send_job(32'd1, 0);

    // A count of zero is taken as one worker and clears the free time.
    quiesce();
    cfg_write(WORKER_COUNT_ADDR, 32'd0);
    send_job(32'd7, 0);

    // Three workers: zero-length jobs keep everyone tied at time zero, so
    // the lowest number must win; then uneven lengths reorder the heap.
    quiesce();
    cfg_write(WORKER_COUNT_ADDR, 32'd3);
    send_job(32'd0, 0);
    send_job(32'd0, 0);
    send_job(32'd10, 0);
    send_job(32'd20, 0);
    send_job(32'd5, 0);
    send_job(32'd1, 0);

    // A write to the unmapped address must leave the heap as it is.
    quiesce();
    cfg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    send_job(32'd2, 0);
    send_job(32'd3, 0);

    // All-ones data keeps 511 in the register field, which clamps to the
    // full heap: long jobs push the root down through every level.
    quiesce();
    cfg_write(WORKER_COUNT_ADDR, 32'hFFFF_FFFF);
    send_job(32'hFFFF_FFFF, 0);
    send_job(32'hFFFF_FFFF, 0);
    send_job(32'hFFFF_FFFF, 0);
    send_job(32'd0, 0);

    // Upper data bits set around a count of two.
    quiesce();
    cfg_write(WORKER_COUNT_ADDR, 32'hFFFF_FE02);
    send_job(32'd1, 0);
    send_job(32'd1, 0);
    send_job(32'd1, 0);
    send_job(32'd1, 0);

    // Random part in three idling regimes: the sender gaps often, then
    // very often, then never. Each segment runs under a fresh worker count,
    // and the pause before every write drains all outstanding results.
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 28 : (phase == 1) ? 71 : 0;
      sent    = 0;
      while (sent < PHASE_JOBS) begin
        quiesce();
        cfg_write(WORKER_COUNT_ADDR, random_count_word());
        seg = $urandom_range(15, 45);
        for (k = 0; k < seg; k++) begin
          // Now and then, mid-segment, poke the unmapped address.
          if (k == seg / 2 && $urandom_range(2) == 0) begin
            quiesce();
            cfg_write(UNMAPPED_ADDR, $urandom);
          end
          send_job(random_duration(), gap_pct);
        end
        sent += seg;
      end
    end

    quiesce();
    if (ledger.errors == 0) begin
      $display("earliest_free_worker_scheduler verification clean");
    end else begin
      $display("earliest_free_worker_scheduler verification failed");
    end
    $finish;
  end

endmodule
